FILE: hdl/pdash_pkg.sv
// ----------------------------------------------------------------------------
// pdash_pkg
// Shared types, constants and pattern helpers for the polyline dash splitter.
// ----------------------------------------------------------------------------
package pdash_pkg;

  localparam int unsigned PATTERN_SLOTS = 8;
  localparam int unsigned MAX_CUTS      = 64;
  localparam int unsigned NIBBLE_BITS   = 4;
  localparam int unsigned REG_NIBBLES   = 8;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned DASH_W   = 32;
  localparam int unsigned PAT_W    = NIBBLE_BITS * REG_NIBBLES;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned FRAC_SH  = 8;
  localparam int unsigned TARGET_W = NIBBLE_BITS + SCALE_W + FRAC_SH;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned ROOT_W   = COORD_W;
  localparam int unsigned LEN_W    = ROOT_W + 1;
  localparam int unsigned RAD_W    = 2 * ROOT_W;
  localparam int unsigned DVD_W    = 64;
  localparam int unsigned MUL_W    = DIFF_W;
  localparam int unsigned SLOT_W   = $clog2(PATTERN_SLOTS);
  localparam int unsigned NPAT_W   = $clog2(PATTERN_SLOTS + 1);
  localparam int unsigned CUT_W    = $clog2(MAX_CUTS + 1);
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DASH_PATTERN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SCALE  = CFG_IDX_W'(1);
  localparam logic [SCALE_W-1:0]   WIDTH_SCALE_RST  = SCALE_W'(256);
  localparam logic [DASH_W-1:0]    DASH_MAX         = '1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      start_of_line;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [DASH_W-1:0]         dash_id;
    logic                      last_of_run;
    logic                      truncated;
  } out_item_t;

  typedef enum logic {
    SRC_PEND,
    SRC_STATE
  } out_src_e;

  typedef struct packed {
    logic     in_load;
    logic     line_start;
    logic     solid;
    logic     cut_clear;
    logic     sq_x;
    logic     sq_y;
    logic     sq_add;
    logic     sqrt_start;
    logic     len_load;
    logic     finish;
    logic     trunc_finish;
    logic     rem_load;
    logic     mul_ix;
    logic     mul_iy;
    logic     div_start;
    logic     qx_load;
    logic     qy_load;
    logic     cut_step;
    logic     pend_load;
    logic     pend_clear;
    logic     out_load;
    out_src_e out_src;
    logic     out_last;
    logic     out_trunc;
  } cmd_t;

  typedef struct packed {
    logic sol;
    logic solid_pat;
    logic sqrt_done;
    logic div_done;
    logic reach;
    logic cut_full;
    logic pen_on;
    logic pend_v;
    logic out_free;
  } status_t;

  function automatic logic [NIBBLE_BITS-1:0] nibble_at(logic [PAT_W-1:0] pat,
                                                       logic [SLOT_W-1:0] k);
    nibble_at = NIBBLE_BITS'(pat >> (32'(k) * NIBBLE_BITS));
  endfunction

  // pairs are taken while the on length of the pair is nonzero
  function automatic logic [NPAT_W-1:0] slot_count(logic [PAT_W-1:0] pat);
    logic [NPAT_W-1:0] n;
    logic              run_ok;
    n = '0;
    run_ok = 1'b1;
    for (int p = 0; p < PATTERN_SLOTS / 2; p++) begin
      if (run_ok && (NIBBLE_BITS'(pat >> (2 * p * NIBBLE_BITS)) != '0)) begin
        n = n + NPAT_W'(2);
      end else begin
        run_ok = 1'b0;
      end
    end
    slot_count = n;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_mod(logic [SLOT_W-1:0] s,
                                                 logic [NPAT_W-1:0] n);
    logic [NPAT_W-1:0] r;
    r = NPAT_W'(s);
    for (int i = 0; i < PATTERN_SLOTS / 2; i++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    slot_mod = SLOT_W'(r);
  endfunction

endpackage

FILE: hdl/pdash_sqrt.sv
// ----------------------------------------------------------------------------
// pdash_sqrt
// Bit-pair restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pdash_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pdash_pkg::RAD_W-1:0] rad_i,
  output logic [pdash_pkg::ROOT_W-1:0] root_o,
  output logic                        done_o
);

  localparam int unsigned CNT_W = $clog2(pdash_pkg::ROOT_W);

  logic [pdash_pkg::RAD_W-1:0] v_q, res_q, bit_w, trial_w;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q, done_q;

  assign bit_w   = pdash_pkg::RAD_W'(1) << {CNT_W'(pdash_pkg::ROOT_W - 1) - cnt_q, 1'b0};
  assign trial_w = res_q + bit_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(pdash_pkg::ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= rad_i;
      res_q <= '0;
    end else if (busy_q) begin
      if (v_q >= trial_w) begin
        v_q   <= v_q - trial_w;
        res_q <= (res_q >> 1) + bit_w;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign root_o = res_q[pdash_pkg::ROOT_W-1:0];
  assign done_o = done_q;

endmodule

FILE: hdl/pdash_div.sv
// ----------------------------------------------------------------------------
// pdash_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdash_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pdash_pkg::DVD_W-1:0] dividend_i,
  input  logic [pdash_pkg::LEN_W-1:0] divisor_i,
  output logic [pdash_pkg::DVD_W-1:0] quot_o,
  output logic                        done_o
);

  localparam int unsigned CNT_W = $clog2(pdash_pkg::DVD_W);

  logic [pdash_pkg::DVD_W-1:0] dvd_q;
  logic [pdash_pkg::LEN_W-1:0] den_q, rem_q;
  logic [pdash_pkg::LEN_W:0]   part_w, diff_w;
  logic                        ge_w;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q, done_q;

  assign part_w = {rem_q, dvd_q[pdash_pkg::DVD_W-1]};
  assign ge_w   = part_w >= {1'b0, den_q};
  assign diff_w = part_w - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(pdash_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge_w ? diff_w[pdash_pkg::LEN_W-1:0] : part_w[pdash_pkg::LEN_W-1:0];
      dvd_q <= {dvd_q[pdash_pkg::DVD_W-2:0], ge_w};
    end
  end

  assign quot_o = dvd_q;
  assign done_o = done_q;

endmodule

FILE: hdl/pdash_dp.sv
// ----------------------------------------------------------------------------
// pdash_dp
// Datapath: config and pen state, shared multiplier, length and cut math,
// pending cut slot and output register.
// ----------------------------------------------------------------------------
module pdash_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pdash_pkg::cmd_t                 cmd_i,
  output pdash_pkg::status_t              sts_o,
  input  pdash_pkg::in_item_t             in_data_i,
  input  logic                            cfg_we_i,
  input  logic [pdash_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pdash_pkg::out_item_t            out_data_o
);

  localparam int unsigned CW        = pdash_pkg::COORD_W;
  localparam int unsigned TW        = pdash_pkg::TARGET_W;
  localparam int unsigned PW        = pdash_pkg::TARGET_W - pdash_pkg::FRAC_SH;
  localparam int unsigned LEN_W_SUM = pdash_pkg::LEN_W + 1;

  logic [pdash_pkg::PAT_W-1:0]   pat_q;
  logic [pdash_pkg::SCALE_W-1:0] scale_q;
  logic [CW-1:0]                 vx_q, vy_q, pen_x_q, pen_y_q;
  logic                          sol_q;
  logic [31:0]                   run_q;
  logic [pdash_pkg::SLOT_W-1:0]  slot_q;
  logic                          pen_on_q;
  logic [pdash_pkg::DASH_W-1:0]  dash_q;
  logic [pdash_pkg::CUT_W-1:0]   cuts_q;

  logic [pdash_pkg::RAD_W-1:0]   prod_q, sum_q;
  logic                          halve_q;
  logic [pdash_pkg::LEN_W-1:0]   len_q, qx_q, qy_q;
  logic [TW-1:0]                 rem_q;
  pdash_pkg::out_item_t          pend_q, out_q;
  logic                          pend_v_q, out_v_q;

  logic [pdash_pkg::DIFF_W-1:0]  dx_w, dy_w, magx_w, magy_w;
  logic                          big_w;
  logic [CW-1:0]                 opx_w, opy_w;
  logic [pdash_pkg::MUL_W-1:0]   mul_a_w, mul_b_w;
  logic [2*pdash_pkg::MUL_W-1:0] mul_p_w;
  logic [pdash_pkg::NPAT_W-1:0]  npat_w;
  logic [pdash_pkg::SLOT_W-1:0]  slot_idx_w, slot_nxt_w;
  logic [PW-1:0]                 tprod_w;
  logic [TW-1:0]                 target_w, rem_nxt_w;
  logic [LEN_W_SUM-1:0]          run_sum_w;
  logic [pdash_pkg::ROOT_W-1:0]  root_w;
  logic [pdash_pkg::DVD_W-1:0]   quot_w;
  logic                          sqrt_done_w, div_done_w;
  logic                          pen_on_nxt_w;
  pdash_pkg::out_item_t          state_res_w, pend_nxt_w, out_nxt_w;

  assign dx_w   = {vx_q[CW-1], vx_q} - {pen_x_q[CW-1], pen_x_q};
  assign dy_w   = {vy_q[CW-1], vy_q} - {pen_y_q[CW-1], pen_y_q};
  assign magx_w = dx_w[pdash_pkg::DIFF_W-1] ? -dx_w : dx_w;
  assign magy_w = dy_w[pdash_pkg::DIFF_W-1] ? -dy_w : dy_w;
  // when either magnitude is at or above 2^31, both are halved before squaring
  assign big_w  = magx_w[CW] | magx_w[CW-1] | magy_w[CW] | magy_w[CW-1];
  assign opx_w  = big_w ? magx_w[CW:1] : magx_w[CW-1:0];
  assign opy_w  = big_w ? magy_w[CW:1] : magy_w[CW-1:0];

  always_comb begin
    mul_a_w = {1'b0, opx_w};
    mul_b_w = {1'b0, opx_w};
    if (cmd_i.sq_y) begin
      mul_a_w = {1'b0, opy_w};
      mul_b_w = {1'b0, opy_w};
    end else if (cmd_i.mul_ix) begin
      mul_a_w = magx_w;
      mul_b_w = pdash_pkg::MUL_W'(rem_q);
    end else if (cmd_i.mul_iy) begin
      mul_a_w = magy_w;
      mul_b_w = pdash_pkg::MUL_W'(rem_q);
    end
  end
  assign mul_p_w = mul_a_w * mul_b_w;

  assign npat_w     = pdash_pkg::slot_count(pat_q);
  assign slot_idx_w = pdash_pkg::slot_mod(slot_q, npat_w);
  assign slot_nxt_w = (pdash_pkg::NPAT_W'(slot_idx_w) + pdash_pkg::NPAT_W'(1) == npat_w) ?
                      '0 : slot_idx_w + pdash_pkg::SLOT_W'(1);
  assign tprod_w    = PW'(pdash_pkg::nibble_at(pat_q, slot_idx_w)) * PW'(scale_q);
  assign target_w   = {tprod_w, pdash_pkg::FRAC_SH'(0)};
  assign run_sum_w  = LEN_W_SUM'(run_q) + LEN_W_SUM'(len_q);
  // a run already past the target leaves nothing to the boundary
  assign rem_nxt_w  = (run_q >= 32'(target_w)) ? '0 : target_w - run_q[TW-1:0];
  assign pen_on_nxt_w = ~pen_on_q;

  pdash_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (sum_q),
    .root_o  (root_w),
    .done_o  (sqrt_done_w)
  );

  pdash_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (len_q),
    .quot_o     (quot_w),
    .done_o     (div_done_w)
  );

  always_comb begin
    state_res_w.out_x       = pen_x_q;
    state_res_w.out_y       = pen_y_q;
    state_res_w.dash_id     = dash_q;
    state_res_w.last_of_run = cmd_i.out_last;
    state_res_w.truncated   = cmd_i.out_trunc;
  end

  always_comb begin
    pend_nxt_w             = state_res_w;
    pend_nxt_w.last_of_run = 1'b0;
    pend_nxt_w.truncated   = 1'b0;
    out_nxt_w              = state_res_w;
    if (cmd_i.out_src == pdash_pkg::SRC_PEND) begin
      out_nxt_w             = pend_q;
      out_nxt_w.last_of_run = cmd_i.out_last;
    end
  end

  // config, pen state, cut count and valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q    <= '0;
      scale_q  <= pdash_pkg::WIDTH_SCALE_RST;
      pen_x_q  <= '0;
      pen_y_q  <= '0;
      run_q    <= '0;
      slot_q   <= '0;
      pen_on_q <= 1'b1;
      dash_q   <= pdash_pkg::DASH_W'(1);
      cuts_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          pdash_pkg::REG_DASH_PATTERN: pat_q   <= cfg_data_i;
          pdash_pkg::REG_WIDTH_SCALE:  scale_q <= cfg_data_i[pdash_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.line_start) begin
        run_q    <= '0;
        slot_q   <= '0;
        pen_on_q <= 1'b1;
        dash_q   <= pdash_pkg::DASH_W'(1);
        pen_x_q  <= vx_q;
        pen_y_q  <= vy_q;
      end
      if (cmd_i.solid) begin
        pen_on_q <= 1'b1;
        pen_x_q  <= vx_q;
        pen_y_q  <= vy_q;
      end
      if (cmd_i.finish || cmd_i.trunc_finish) begin
        pen_x_q <= vx_q;
        pen_y_q <= vy_q;
      end
      if (cmd_i.finish && (len_q != '0)) begin
        run_q <= run_sum_w[31:0];
      end
      if (cmd_i.cut_clear) begin
        cuts_q <= '0;
      end
      if (cmd_i.cut_step) begin
        pen_x_q  <= dx_w[pdash_pkg::DIFF_W-1] ? pen_x_q - qx_q[CW-1:0]
                                              : pen_x_q + qx_q[CW-1:0];
        pen_y_q  <= dy_w[pdash_pkg::DIFF_W-1] ? pen_y_q - qy_q[CW-1:0]
                                              : pen_y_q + qy_q[CW-1:0];
        slot_q   <= slot_nxt_w;
        run_q    <= '0;
        pen_on_q <= pen_on_nxt_w;
        if (pen_on_nxt_w && (dash_q != pdash_pkg::DASH_MAX)) begin
          dash_q <= dash_q + pdash_pkg::DASH_W'(1);
        end
        cuts_q   <= cuts_q + pdash_pkg::CUT_W'(1);
      end
      if (cmd_i.pend_clear) begin
        pend_v_q <= 1'b0;
      end
      if (cmd_i.pend_load) begin
        pend_v_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      vx_q  <= in_data_i.x_coord;
      vy_q  <= in_data_i.y_coord;
      sol_q <= in_data_i.start_of_line;
    end
    if (cmd_i.sq_x || cmd_i.sq_y || cmd_i.mul_ix || cmd_i.mul_iy) begin
      prod_q <= mul_p_w[pdash_pkg::RAD_W-1:0];
    end
    if (cmd_i.sq_x) begin
      halve_q <= big_w;
    end
    if (cmd_i.sq_y) begin
      sum_q <= prod_q;
    end
    if (cmd_i.sq_add) begin
      sum_q <= sum_q + prod_q;
    end
    if (cmd_i.len_load) begin
      len_q <= halve_q ? {root_w, 1'b0} : {1'b0, root_w};
    end
    if (cmd_i.rem_load) begin
      rem_q <= rem_nxt_w;
    end
    if (cmd_i.qx_load) begin
      qx_q <= quot_w[pdash_pkg::LEN_W-1:0];
    end
    if (cmd_i.qy_load) begin
      qy_q <= quot_w[pdash_pkg::LEN_W-1:0];
    end
    if (cmd_i.pend_load) begin
      pend_q <= pend_nxt_w;
    end
    if (cmd_i.out_load) begin
      out_q <= out_nxt_w;
    end
  end

  always_comb begin
    sts_o.sol       = sol_q;
    sts_o.solid_pat = (npat_w == '0);
    sts_o.sqrt_done = sqrt_done_w;
    sts_o.div_done  = div_done_w;
    sts_o.reach     = (len_q == '0) || (run_sum_w < LEN_W_SUM'(target_w));
    sts_o.cut_full  = cuts_q >= pdash_pkg::CUT_W'(pdash_pkg::MAX_CUTS - 1);
    sts_o.pen_on    = pen_on_q;
    sts_o.pend_v    = pend_v_q;
    sts_o.out_free  = !out_v_q || !out_stall_i;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/pdash_ctrl.sv
// ----------------------------------------------------------------------------
// pdash_ctrl
// Sequencer: walks one vertex through length, cut and emit steps.
// ----------------------------------------------------------------------------
module pdash_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pdash_pkg::status_t sts_i,
  output pdash_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_MULX,
    ST_MULY,
    ST_ADDSQ,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DECIDE,
    ST_MULIX,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_MULIY,
    ST_DIVY_GO,
    ST_DIVY_WAIT,
    ST_STEP,
    ST_CUT_PEND,
    ST_EMIT_VTX,
    ST_EMIT_LAST
  } state_e;

  state_e state_q, state_d;
  logic   trunc_q, trunc_d;

  always_comb begin
    state_d = state_q;
    trunc_d = trunc_q;
    cmd_o   = '0;
    cmd_o.out_src = pdash_pkg::SRC_STATE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        trunc_d = 1'b0;
        if (sts_i.sol) begin
          cmd_o.line_start = 1'b1;
          state_d = ST_EMIT_VTX;
        end else if (sts_i.solid_pat) begin
          cmd_o.solid = 1'b1;
          state_d = ST_EMIT_VTX;
        end else begin
          cmd_o.cut_clear = 1'b1;
          state_d = ST_MULX;
        end
      end
      ST_MULX: begin
        cmd_o.sq_x = 1'b1;
        state_d = ST_MULY;
      end
      ST_MULY: begin
        cmd_o.sq_y = 1'b1;
        state_d = ST_ADDSQ;
      end
      ST_ADDSQ: begin
        cmd_o.sq_add = 1'b1;
        state_d = ST_SQRT_GO;
      end
      ST_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.len_load = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.reach) begin
          cmd_o.finish = 1'b1;
          if (sts_i.pen_on) begin
            state_d = ST_EMIT_VTX;
          end else if (sts_i.pend_v) begin
            state_d = ST_EMIT_LAST;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (sts_i.cut_full) begin
          cmd_o.trunc_finish = 1'b1;
          trunc_d = 1'b1;
          state_d = ST_EMIT_VTX;
        end else begin
          cmd_o.rem_load = 1'b1;
          state_d = ST_MULIX;
        end
      end
      ST_MULIX: begin
        cmd_o.mul_ix = 1'b1;
        state_d = ST_DIVX_GO;
      end
      ST_DIVX_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIVX_WAIT;
      end
      ST_DIVX_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.qx_load = 1'b1;
          state_d = ST_MULIY;
        end
      end
      ST_MULIY: begin
        cmd_o.mul_iy = 1'b1;
        state_d = ST_DIVY_GO;
      end
      ST_DIVY_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIVY_WAIT;
      end
      ST_DIVY_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.qy_load = 1'b1;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.cut_step = 1'b1;
        state_d = ST_CUT_PEND;
      end
      // a cut waits in the pending slot until we know whether it ends the run
      ST_CUT_PEND: begin
        if (!sts_i.pend_v) begin
          cmd_o.pend_load = 1'b1;
          state_d = ST_MULX;
        end else if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_src   = pdash_pkg::SRC_PEND;
          cmd_o.pend_load = 1'b1;
          state_d = ST_MULX;
        end
      end
      ST_EMIT_VTX: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.pend_v) begin
            cmd_o.out_src    = pdash_pkg::SRC_PEND;
            cmd_o.pend_clear = 1'b1;
          end else begin
            cmd_o.out_last  = 1'b1;
            cmd_o.out_trunc = trunc_q;
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT_LAST: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_src    = pdash_pkg::SRC_PEND;
          cmd_o.out_last   = 1'b1;
          cmd_o.pend_clear = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      trunc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      trunc_q <= trunc_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

FILE: hdl/polyline_dash_pattern.sv
// Dashed vertices wait on a square root for the segment length; each cut adds two
// divisions and a fresh length, plus output wait. Start-of-line and solid vertices skip both.
// Throughput: one vertex at a time; next vertex accepted once the sequencer is back in idle.
// Reset: async active low; pen at origin, pen on, dash id 1, width scale 1.0.
// ----------------------------------------------------------------------------
// polyline_dash_pattern
// Splits a polyline into dashes with interpolated cut points.
// ----------------------------------------------------------------------------
module polyline_dash_pattern (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pdash_pkg::in_item_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pdash_pkg::out_item_t            out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pdash_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);

  pdash_pkg::cmd_t    cmd;
  pdash_pkg::status_t sts;

  assign cfg_ready_o = 1'b1;

  pdash_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pdash_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hdl/pdash_chk.sv
// ----------------------------------------------------------------------------
// pdash_chk
// Port-level checks for the dash splitter, bound to the top level.
// ----------------------------------------------------------------------------
module pdash_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input pdash_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second vertex taken while one is in work");

  a_dash_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.dash_id != '0)
    else $error("dash id zero");

  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.truncated |-> out_data_o.last_of_run)
    else $error("truncated result not last of run");

endmodule

bind polyline_dash_pattern pdash_chk u_pdash_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
